[rtl/core/tlic_pkg.sv]
// Shared types, geometry constants and register codes of the two-level cache model.
package tlic_pkg;

	localparam int L1_LINES  = 256;
	localparam int L2_BLOCKS = 4096;
	localparam int MAX_WAYS  = 8;

	localparam int L1_IDX_W = $clog2(L1_LINES);
	localparam int L2_IDX_W = $clog2(L2_BLOCKS);
	localparam int LANE_W   = $clog2(MAX_WAYS);
	localparam int ROWS     = L2_BLOCKS / MAX_WAYS;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int IB_W     = $clog2(L1_IDX_W + 1);
	localparam int SB_W     = $clog2(L2_IDX_W + 1);
	localparam int ADDR_W   = 32;
	localparam int STAMP_W  = 32;
	localparam int VBLK_W   = ADDR_W + L2_IDX_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_SIZE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS    = 2'd3;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} item_t;

	typedef struct packed {
		logic l1_hit;
		logic l2_hit;
		logic write_back;
	} result_t;

	// One classified access, as handed from the front to the back.
	typedef struct packed {
		logic                wr;
		logic [L1_IDX_W-1:0] i1;
		logic [ADDR_W-1:0]   t1;
		logic [ADDR_W-1:0]   t2;
		logic [L2_IDX_W-1:0] set;
		logic [ROW_W-1:0]    row;
		logic [LANE_W-1:0]   lane;
		logic [1:0]          wb;
		logic [SB_W-1:0]     sb;
		logic [IB_W-1:0]     ib1;
		logic [STAMP_W-1:0]  stamp;
	} job_t;

	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic              dirty;
	} l1_ent_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
		logic               valid;
		logic               dirty;
	} l2_ent_t;

	typedef l2_ent_t [MAX_WAYS-1:0] l2_row_t;

	// Handshake between front queue and back sequencer.
	typedef struct packed {
		logic valid;
		job_t job;
	} job_chan_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} back_stat_t;

endpackage

[rtl/core/tlic_ram.sv]
// Generic single-write, single-read memory with registered read data.
module tlic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/tlic_front.sv]
// Front part: configuration registers, address decomposition and a two-entry job queue.
module tlic_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlic_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tlic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	input  tlic_pkg::item_t                  item,
	output logic                             full,
	output tlic_pkg::job_chan_t              chan,
	input  tlic_pkg::back_stat_t             stat
);

	logic [3:0] bsz_q;
	logic [4:0] l1sz_q;
	logic [4:0] l2sz_q;
	logic [1:0] ways_q;
	logic [tlic_pkg::STAMP_W-1:0] count_q;

	tlic_pkg::job_t q_mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	logic [4:0]  ib1_raw;
	logic [4:0]  ib1;
	logic [1:0]  wb;
	logic [5:0]  bs_sum;
	logic [5:0]  sb_raw;
	logic [5:0]  lim2;
	logic [5:0]  sb;
	logic [tlic_pkg::ADDR_W-1:0]   blk;
	logic [tlic_pkg::L2_IDX_W-1:0] set;
	logic [tlic_pkg::L2_IDX_W-1:0] base_ent;
	tlic_pkg::job_t new_job;
	logic accept;

	always_comb begin
		ib1_raw = (l1sz_q > 5'(bsz_q)) ? (l1sz_q - 5'(bsz_q)) : 5'd0;
		ib1 = (ib1_raw > 5'(tlic_pkg::L1_IDX_W)) ? 5'(tlic_pkg::L1_IDX_W) : ib1_raw;
		wb = (32'(ways_q) > 32'(tlic_pkg::LANE_W)) ? 2'(tlic_pkg::LANE_W) : ways_q;
		bs_sum = 6'(bsz_q) + 6'(ways_q);
		sb_raw = (6'(l2sz_q) > bs_sum) ? (6'(l2sz_q) - bs_sum) : 6'd0;
		lim2 = 6'(tlic_pkg::L2_IDX_W) - 6'(wb);
		sb = (sb_raw > lim2) ? lim2 : sb_raw;

		blk = item.address >> bsz_q;
		set = tlic_pkg::L2_IDX_W'(blk & ~({tlic_pkg::ADDR_W{1'b1}} << sb));
		base_ent = set << wb;

		new_job.wr    = item.mode;
		new_job.i1    = tlic_pkg::L1_IDX_W'(blk & ~({tlic_pkg::ADDR_W{1'b1}} << ib1));
		new_job.t1    = blk >> ib1;
		new_job.t2    = blk >> sb;
		new_job.set   = set;
		new_job.row   = base_ent[tlic_pkg::L2_IDX_W-1:tlic_pkg::LANE_W];
		new_job.lane  = base_ent[tlic_pkg::LANE_W-1:0];
		new_job.wb    = wb;
		new_job.sb    = tlic_pkg::SB_W'(sb);
		new_job.ib1   = tlic_pkg::IB_W'(ib1);
		new_job.stamp = count_q + 1'b1;
	end

	assign full       = (cnt_q == 2'd2) || stat.clearing;
	assign accept     = push && !full;
	assign chan.valid = (cnt_q != 2'd0);
	assign chan.job   = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wp_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q   <= 4'd5;
			l1sz_q  <= 5'd13;
			l2sz_q  <= 5'd17;
			ways_q  <= 2'd3;
			count_q <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tlic_pkg::CFG_BLOCK_SIZE: bsz_q  <= cfg_data[3:0];
					tlic_pkg::CFG_L1_SIZE:    l1sz_q <= cfg_data;
					tlic_pkg::CFG_L2_SIZE:    l2sz_q <= cfg_data;
					tlic_pkg::CFG_L2_WAYS:    ways_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (accept) begin
				count_q <= count_q + 1'b1;
				wp_q    <= ~wp_q;
			end
			if (stat.take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(accept) - 2'(stat.take);
		end
	end

endmodule

[rtl/core/tlic_back.sv]
// Back part: lookup, fill and eviction sequencer over the L1 and L2 memories.
module tlic_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tlic_pkg::job_chan_t   chan,
	output tlic_pkg::back_stat_t  stat,
	input  logic                  pop,
	output logic                  empty,
	output tlic_pkg::result_t     result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_VICT,
		ST_VADDR,
		ST_VL1
	} state_t;

	state_t state_q;
	tlic_pkg::job_t    job_q;
	tlic_pkg::l2_row_t row_q;
	logic [tlic_pkg::L1_LINES-1:0] l1_valid_q;
	logic [tlic_pkg::LANE_W-1:0] vic_q;
	logic [tlic_pkg::LANE_W-1:0] scan_q;
	logic clr_q;
	logic [tlic_pkg::ROW_W-1:0] clr_cnt_q;
	tlic_pkg::result_t res_q;
	logic res_valid_q;

	logic start;
	logic [tlic_pkg::MAX_WAYS-1:0] in_set;
	logic hit_any;
	logic free_any;
	logic [tlic_pkg::LANE_W-1:0] hit_lane;
	logic [tlic_pkg::LANE_W-1:0] free_lane;
	logic [tlic_pkg::LANE_W-1:0] last_lane;
	logic l1_hit;

	logic [tlic_pkg::VBLK_W-1:0]   vblk;
	logic [tlic_pkg::L1_IDX_W-1:0] vi1;
	logic [tlic_pkg::VBLK_W-1:0]   vt1;
	logic vmatch;

	logic l1_we;
	logic [tlic_pkg::L1_IDX_W-1:0] l1_waddr;
	tlic_pkg::l1_ent_t l1_wdata;
	logic l1_re;
	logic [tlic_pkg::L1_IDX_W-1:0] l1_raddr;
	tlic_pkg::l1_ent_t l1_rdata;

	logic l2_we;
	logic [tlic_pkg::ROW_W-1:0] l2_waddr;
	tlic_pkg::l2_row_t l2_wdata;
	tlic_pkg::l2_row_t l2_rdata;
	tlic_pkg::l2_ent_t fill_ent;

	assign start = (state_q == ST_IDLE) && chan.valid && !clr_q && (!res_valid_q || pop);
	assign stat.take     = start;
	assign stat.clearing = clr_q;
	assign empty  = !res_valid_q;
	assign result = res_q;

	always_comb begin
		in_set    = '0;
		hit_any   = 1'b0;
		free_any  = 1'b0;
		hit_lane  = '0;
		free_lane = '0;
		for (int l = 0; l < tlic_pkg::MAX_WAYS; l++) begin
			in_set[l] = ((tlic_pkg::LANE_W'(l) ^ job_q.lane) >> job_q.wb) == '0;
		end
		for (int l = tlic_pkg::MAX_WAYS - 1; l >= 0; l--) begin
			if (in_set[l] && l2_rdata[l].valid && (l2_rdata[l].tag == job_q.t2)) begin
				hit_any  = 1'b1;
				hit_lane = tlic_pkg::LANE_W'(l);
			end
		end
		for (int l = 0; l < tlic_pkg::MAX_WAYS; l++) begin
			if (in_set[l] && !l2_rdata[l].valid) begin
				free_any  = 1'b1;
				free_lane = tlic_pkg::LANE_W'(l);
			end
		end
		last_lane = job_q.lane | tlic_pkg::LANE_W'(~({tlic_pkg::LANE_W{1'b1}} << job_q.wb));
		l1_hit = l1_valid_q[job_q.i1] && (l1_rdata.tag == job_q.t1);

		vblk = (tlic_pkg::VBLK_W'(row_q[vic_q].tag) << job_q.sb) | tlic_pkg::VBLK_W'(job_q.set);
		vi1  = tlic_pkg::L1_IDX_W'(vblk) & ~({tlic_pkg::L1_IDX_W{1'b1}} << job_q.ib1);
		vt1  = vblk >> job_q.ib1;
		vmatch = l1_valid_q[vi1] && (vt1 == tlic_pkg::VBLK_W'(l1_rdata.tag));

		fill_ent.tag   = job_q.t2;
		fill_ent.stamp = job_q.stamp;
		fill_ent.valid = 1'b1;
		fill_ent.dirty = job_q.wr;
	end

	// Memory port control.
	always_comb begin
		l1_re    = 1'b0;
		l1_raddr = chan.job.i1;
		l1_we    = 1'b0;
		l1_waddr = job_q.i1;
		l1_wdata.tag   = job_q.t1;
		l1_wdata.dirty = job_q.wr;
		l2_we    = 1'b0;
		l2_waddr = job_q.row;
		l2_wdata = l2_rdata;
		case (state_q)
			ST_IDLE: begin
				l1_re = start;
			end
			ST_LOOK: begin
				if (l1_hit) begin
					l1_we = job_q.wr;
					l1_wdata.dirty = 1'b1;
					if (hit_any) begin
						l2_we = 1'b1;
						l2_wdata[hit_lane].stamp = job_q.stamp;
						l2_wdata[hit_lane].dirty = l2_rdata[hit_lane].dirty | job_q.wr;
					end
				end else begin
					l1_we = 1'b1;
					if (hit_any) begin
						l2_we = 1'b1;
						l2_wdata[hit_lane].stamp = job_q.stamp;
						l2_wdata[hit_lane].dirty = l2_rdata[hit_lane].dirty | job_q.wr;
					end else if (free_any) begin
						l2_we = 1'b1;
						l2_wdata[free_lane] = fill_ent;
					end
				end
			end
			ST_VADDR: begin
				l1_re    = 1'b1;
				l1_raddr = vi1;
			end
			ST_VL1: begin
				l2_we = 1'b1;
				l2_wdata = row_q;
				l2_wdata[vic_q] = fill_ent;
			end
			default: ;
		endcase
		if (clr_q) begin
			l2_we    = 1'b1;
			l2_waddr = clr_cnt_q;
			l2_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= chan.job;
		end
		if (state_q == ST_LOOK) begin
			row_q <= l2_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			l1_valid_q  <= '0;
			vic_q       <= '0;
			scan_q      <= '0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == tlic_pkg::ROW_W'(tlic_pkg::ROWS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (!l1_hit) begin
						l1_valid_q[job_q.i1] <= 1'b1;
					end
					if (l1_hit || hit_any || free_any) begin
						res_q.l1_hit     <= l1_hit;
						res_q.l2_hit     <= !l1_hit && hit_any;
						res_q.write_back <= 1'b0;
						res_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end else begin
						vic_q  <= job_q.lane;
						scan_q <= job_q.lane + 1'b1;
						state_q <= (job_q.lane == last_lane) ? ST_VADDR : ST_VICT;
					end
				end
				ST_VICT: begin
					if (row_q[scan_q].stamp < row_q[vic_q].stamp) begin
						vic_q <= scan_q;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == last_lane) begin
						state_q <= ST_VADDR;
					end
				end
				ST_VADDR: begin
					state_q <= ST_VL1;
				end
				ST_VL1: begin
					if (vmatch) begin
						l1_valid_q[vi1] <= 1'b0;
					end
					res_q.l1_hit     <= 1'b0;
					res_q.l2_hit     <= 1'b0;
					res_q.write_back <= row_q[vic_q].dirty || (vmatch && l1_rdata.dirty);
					res_valid_q      <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tlic_ram #(
		.WIDTH($bits(tlic_pkg::l1_ent_t)),
		.DEPTH(tlic_pkg::L1_LINES)
	) u_l1_ram (
		.clk  (clk),
		.we   (l1_we),
		.waddr(l1_waddr),
		.wdata(l1_wdata),
		.re   (l1_re),
		.raddr(l1_raddr),
		.rdata(l1_rdata)
	);

	tlic_ram #(
		.WIDTH($bits(tlic_pkg::l2_row_t)),
		.DEPTH(tlic_pkg::ROWS)
	) u_l2_ram (
		.clk  (clk),
		.we   (l2_we),
		.waddr(l2_waddr),
		.wdata(l2_wdata),
		.re   (start),
		.raddr(chan.job.row),
		.rdata(l2_rdata)
	);

endmodule

[rtl/core/two_level_inclusive_cache_model.sv]
// Top level of the two-level inclusive cache model: front queue and back sequencer.
//
// Each beat pushed in is one read or write; each beat popped out tells whether L1 hit,
// whether L2 hit on an L1 miss, and whether an L2 eviction wrote a dirty block back.
// The L1 is direct mapped with 256 lines and the L2 holds 4096 blocks in rows of eight
// ways; a set never spans two rows, so one row read gives every way of a set. After
// reset the block sweeps the L2 memory once to clear valid bits, dirty bits and
// timestamps, one row a cycle, and holds full high until the sweep is done;
// configuration writes are taken during that time. The front classifies an access in
// the cycle it is accepted and queues up to two of them. The back handles an access
// that hits L1 or L2 or fills a free way with a memory read, then compare and update.
// An access that must evict also runs a victim search that steps through the ways of
// the set one per cycle, and the victim's L1 line needs a second read of the single
// L1 memory port. A finished result waits in an output register until popped,
// and the back starts the next access only once that register is free.
module two_level_inclusive_cache_model (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlic_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tlic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	input  tlic_pkg::item_t                  item,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output tlic_pkg::result_t                result
);

	tlic_pkg::job_chan_t  chan;
	tlic_pkg::back_stat_t stat;

	// Front: registers, address split into L1 and L2 coordinates, and the job queue.
	tlic_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.push    (push),
		.item    (item),
		.full    (full),
		.chan    (chan),
		.stat    (stat)
	);

	// Back: lookup, fill, victim choice and L1 back-invalidation.
	tlic_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.chan  (chan),
		.stat  (stat),
		.pop   (pop),
		.empty (empty),
		.result(result)
	);

endmodule
